/* hw/rtl/ssl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_pkg: shared types and constants of the sorted set list
// Sizes, command and status codes, datapath operations and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CW       = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OUT_CW   = 6;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ST_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_READOUT = 2'd2
  } ssl_cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ITEM      = 3'd5,
    ST_EMPTY     = 3'd6
  } ssl_status_e;

  typedef enum logic [3:0] {
    OP_IDLE       = 4'd0,
    OP_LOAD       = 4'd1,
    OP_FWD        = 4'd2,
    OP_FWD_SHIFT  = 4'd3,
    OP_SETUP_DN   = 4'd4,
    OP_SETUP_UP   = 4'd5,
    OP_BWD_SHIFT  = 4'd6,
    OP_INS_COMMIT = 4'd7,
    OP_DEL_COMMIT = 4'd8,
    OP_RD_ISSUE   = 4'd9,
    OP_EMIT       = 4'd10,
    OP_EMIT_ITEM  = 4'd11
  } ssl_op_e;

  typedef struct packed {
    ssl_op_e     op;
    ssl_status_e status;
  } ssl_cmd_t;

  typedef struct packed {
    logic rv;         // read data register holds a scanned entry
    logic lt;         // scanned entry < key
    logic eq;         // scanned entry == key
    logic scan_done;  // forward scan reached the end of the list
    logic bwd_done;   // backward shift reached the insert slot
    logic full;
    logic empty;
    logic item_last;  // readout pointer on the final entry
    logic out_free;   // output register can take a result this cycle
  } ssl_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/sorted_set_list_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_list_top: ascending duplicate-free list of signed keys
// Insert, delete and readout over a store of CAPACITY 32-bit keys.
// ----------------------------------------------------------------------------
// One item is worked at a time. The next item is taken once the current one
// has handed its last result to the output register. All timing is set by
// the key store's single read port, which reads one entry per cycle.
// Each result waits while out_stall_i holds the previous result.
// - Insert: an accept step, a forward search up to the insert slot, a
//   backward shift of the entries from the end down to that slot, the
//   write of the key, and one result.
// - Delete: an accept step, a forward search up to the entry, a shift of
//   the entries above it one slot down, the commit, and one result.
// - Not found, duplicate or full: an accept step, the search and one result.
// - Readout: an accept step, then a read and an emit step per stored key.
//   An empty list gives a single result with status empty.
// Command code 3 is taken and dropped with no result. The store needs no
// clearing after reset, because only entries below the count are read.
// Results sit in an output register, so a new item is taken while the
// last result still waits on out_stall_i.
// ----------------------------------------------------------------------------
module sorted_set_list_top import ssl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        in_command_i,
  input  logic signed [KEY_W-1:0] in_key_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ST_W-1:0]         out_status_o,
  output logic signed [KEY_W-1:0] out_value_o,
  output logic [OUT_CW-1:0]       out_count_o,
  output logic                    out_last_o
);

  ssl_cmd_t  cmd;
  ssl_stat_t stat;

  // sequencer: search, shift, commit, emit
  ssl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_command_i (in_command_i),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // key store, pointers, count and output register
  ssl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_key_i     (in_key_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_status_o (out_status_o),
    .out_value_o  (out_value_o),
    .out_count_o  (out_count_o),
    .out_last_o   (out_last_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/ssl_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_dp: datapath of the sorted set list
// Key store with one write and one registered read port, scan pointers,
// entry count and the output register.
// ----------------------------------------------------------------------------
module ssl_dp import ssl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssl_cmd_t                cmd_i,
  output ssl_stat_t               stat_o,
  input  logic signed [KEY_W-1:0] in_key_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [ST_W-1:0]         out_status_o,
  output logic signed [KEY_W-1:0] out_value_o,
  output logic [OUT_CW-1:0]       out_count_o,
  output logic                    out_last_o
);

  logic signed [KEY_W-1:0] mem [CAPACITY];

  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [KEY_W-1:0] rdata_q;
  logic [CW-1:0]           ptr_q, ptr_d;
  logic [CW-1:0]           pos_q, pos_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           ptr_dec;
  logic [AW-1:0]           ridx_q, ridx_d;
  logic                    rv_q, rv_d;

  logic                    mem_re, mem_we;
  logic [AW-1:0]           mem_raddr, mem_waddr;
  logic signed [KEY_W-1:0] mem_wdata;

  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  logic [ST_W-1:0]         out_status_q, out_status_d;
  logic signed [KEY_W-1:0] out_value_q, out_value_d;
  logic [OUT_CW-1:0]       out_count_q, out_count_d;
  logic                    out_last_q, out_last_d;

  logic                    out_free;
  logic                    item_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign item_last = ((ptr_q + CW'(1)) == count_q);
  assign ptr_dec   = ptr_q - CW'(1);

  assign stat_o.rv        = rv_q;
  assign stat_o.lt        = (rdata_q < key_q);
  assign stat_o.eq        = (rdata_q == key_q);
  assign stat_o.scan_done = !rv_q && (ptr_q == count_q);
  assign stat_o.bwd_done  = !rv_q && (ptr_q == pos_q);
  assign stat_o.full      = (count_q == CW'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.item_last = item_last;
  assign stat_o.out_free  = out_free;

  always_comb begin
    key_d        = key_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    count_d      = count_q;
    ridx_d       = ridx_q;
    rv_d         = rv_q;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q[AW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = ridx_q;
    mem_wdata    = rdata_q;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    unique case (cmd_i.op)
      OP_IDLE: begin
      end
      OP_LOAD: begin
        key_d = in_key_i;
        ptr_d = '0;
        rv_d  = 1'b0;
      end
      OP_FWD, OP_FWD_SHIFT: begin
        if (ptr_q != count_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[AW-1:0];
          ridx_d    = ptr_q[AW-1:0];
          rv_d      = 1'b1;
          ptr_d     = ptr_q + CW'(1);
        end else begin
          rv_d = 1'b0;
        end
        // closing the gap: entry moves one slot down
        if (cmd_i.op == OP_FWD_SHIFT && rv_q) begin
          mem_we    = 1'b1;
          mem_waddr = ridx_q - AW'(1);
        end
      end
      OP_SETUP_DN: begin
        ptr_d = CW'(ridx_q) + CW'(1);
        rv_d  = 1'b0;
      end
      OP_SETUP_UP: begin
        // hit: insert in front of the scanned entry, else append
        pos_d = rv_q ? CW'(ridx_q) : count_q;
        ptr_d = count_q;
        rv_d  = 1'b0;
      end
      OP_BWD_SHIFT: begin
        if (ptr_q != pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_dec[AW-1:0];
          ridx_d    = ptr_dec[AW-1:0];
          rv_d      = 1'b1;
          ptr_d     = ptr_dec;
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          mem_we    = 1'b1;
          mem_waddr = ridx_q + AW'(1);
        end
      end
      OP_INS_COMMIT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = key_q;
        count_d   = count_q + CW'(1);
      end
      OP_DEL_COMMIT: begin
        count_d = count_q - CW'(1);
      end
      OP_RD_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_q[AW-1:0];
      end
      OP_EMIT: begin
        out_load     = 1'b1;
        out_valid_d  = 1'b1;
        out_status_d = cmd_i.status;
        out_value_d  = (cmd_i.status == ST_EMPTY) ? '0 : key_q;
        out_count_d  = OUT_CW'(count_q);
        out_last_d   = 1'b1;
      end
      OP_EMIT_ITEM: begin
        out_load     = 1'b1;
        out_valid_d  = 1'b1;
        out_status_d = ST_ITEM;
        out_value_d  = rdata_q;
        out_count_d  = OUT_CW'(count_q);
        out_last_d   = item_last;
        ptr_d        = ptr_q + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      ridx_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      ridx_q      <= ridx_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_count_o  = out_count_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT || cmd_i.op == OP_EMIT_ITEM) |-> out_free)
    else $error("result loaded over a pending result");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_INS_COMMIT) |-> (count_q != CW'(CAPACITY)))
    else $error("insert committed on a full list");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_INS_COMMIT) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("count not bumped after insert");

  a_del_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DEL_COMMIT) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("count not dropped after delete");
`endif

endmodule
`default_nettype wire

/* hw/rtl/ssl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_ctrl: controller of the sorted set list
// Sequences search, shift, commit and result phases of each item.
// ----------------------------------------------------------------------------
module ssl_ctrl import ssl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] in_command_i,
  input  ssl_stat_t        stat_i,
  output ssl_cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SRCH_INS = 8'b0000_0010,
    S_SRCH_DEL = 8'b0000_0100,
    S_SHIFT_UP = 8'b0000_1000,
    S_SHIFT_DN = 8'b0001_0000,
    S_RD_ADDR  = 8'b0010_0000,
    S_RD_EMIT  = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } ssl_state_e;

  ssl_state_e  state_q, state_d;
  ssl_status_e st_q, st_d;
  logic        ins_hit;
  logic        del_hit;

  // insert stops at the first entry not below the key
  assign ins_hit = stat_i.rv && !stat_i.lt;
  assign del_hit = stat_i.rv && stat_i.eq;

  always_comb begin
    state_d      = state_q;
    st_d         = st_q;
    cmd_o.op     = OP_IDLE;
    cmd_o.status = st_q;
    in_stall_o   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          unique case (in_command_i)
            CMD_INSERT:  state_d = S_SRCH_INS;
            CMD_DELETE:  state_d = S_SRCH_DEL;
            CMD_READOUT: begin
              if (stat_i.empty) begin
                st_d    = ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                state_d = S_RD_ADDR;
              end
            end
            default: state_d = S_IDLE;  // unused code: dropped
          endcase
        end
      end
      S_SRCH_INS: begin
        if (ins_hit && stat_i.eq) begin
          st_d    = ST_DUPLICATE;
          state_d = S_EMIT;
        end else if (ins_hit || stat_i.scan_done) begin
          if (stat_i.full) begin
            st_d    = ST_FULL;
            state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_SETUP_UP;
            state_d  = S_SHIFT_UP;
          end
        end else begin
          cmd_o.op = OP_FWD;
        end
      end
      S_SRCH_DEL: begin
        if (del_hit) begin
          cmd_o.op = OP_SETUP_DN;
          state_d  = S_SHIFT_DN;
        end else if (stat_i.scan_done) begin
          st_d    = ST_NOT_FOUND;
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_FWD;
        end
      end
      S_SHIFT_UP: begin
        if (stat_i.bwd_done) begin
          cmd_o.op = OP_INS_COMMIT;
          st_d     = ST_INSERTED;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = OP_BWD_SHIFT;
        end
      end
      S_SHIFT_DN: begin
        if (stat_i.scan_done) begin
          cmd_o.op = OP_DEL_COMMIT;
          st_d     = ST_DELETED;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = OP_FWD_SHIFT;
        end
      end
      S_RD_ADDR: begin
        cmd_o.op = OP_RD_ISSUE;
        state_d  = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_ITEM;
          state_d  = stat_i.item_last ? S_IDLE : S_RD_ADDR;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule
`default_nettype wire

/* dv/sorted_set_list_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_list_checker: result predictor and scoreboard for the sorted set
// Mirrors the key set on every accepted item and checks each accepted
// result, field by field, against the oldest pending expectation.
// ----------------------------------------------------------------------------
module sorted_set_list_checker import ssl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [CMD_W-1:0]        in_command_i,
  input  logic signed [KEY_W-1:0] in_key_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [ST_W-1:0]         out_status_i,
  input  logic signed [KEY_W-1:0] out_value_i,
  input  logic [OUT_CW-1:0]       out_count_i,
  input  logic                    out_last_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    ssl_status_e             status;
    logic signed [KEY_W-1:0] value;
    logic [OUT_CW-1:0]       count;
    logic                    last;
  } ssl_result_t;

  logic signed [KEY_W-1:0] set_keys[$];  // ascending, no duplicates
  ssl_result_t             want_q[$];
  int                      fails   = 0;
  int                      pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fails++;
  endtask

  function automatic ssl_result_t make_result(input ssl_status_e st,
                                              input logic signed [KEY_W-1:0] val,
                                              input logic lst);
    ssl_result_t r;
    r.status = st;
    r.value  = val;
    r.count  = OUT_CW'(set_keys.size());
    r.last   = lst;
    return r;
  endfunction

  task automatic predict_item(input logic [CMD_W-1:0] cmd,
                              input logic signed [KEY_W-1:0] key);
    int slot;
    int n;
    slot = 0;
    n    = set_keys.size();
    case (cmd)
      CMD_INSERT: begin
        while (slot < n && set_keys[slot] < key) slot++;
        // duplicate wins over full
        if (slot < n && set_keys[slot] == key) begin
          want_q.push_back(make_result(ST_DUPLICATE, key, 1'b1));
        end else if (n >= int'(CAPACITY)) begin
          want_q.push_back(make_result(ST_FULL, key, 1'b1));
        end else begin
          set_keys.insert(slot, key);
          want_q.push_back(make_result(ST_INSERTED, key, 1'b1));
        end
      end
      CMD_DELETE: begin
        while (slot < n && set_keys[slot] != key) slot++;
        if (slot >= n) begin
          want_q.push_back(make_result(ST_NOT_FOUND, key, 1'b1));
        end else begin
          set_keys.delete(slot);
          want_q.push_back(make_result(ST_DELETED, key, 1'b1));
        end
      end
      CMD_READOUT: begin
        if (n == 0) begin
          want_q.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          foreach (set_keys[i]) begin
            want_q.push_back(make_result(ST_ITEM, set_keys[i], i == n - 1));
          end
        end
      end
      default: ;  // undefined command: dropped, no result
    endcase
  endtask

  task automatic check_result();
    ssl_result_t want;
    if (want_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result status %0d value %0d count %0d last %0b",
                                out_status_i, out_value_i, out_count_i, out_last_i));
      return;
    end
    want = want_q.pop_front();
    if (out_status_i !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", out_status_i, want.status));
    if (out_value_i !== want.value)
      report_mismatch($sformatf("value %0d, want %0d", out_value_i, want.value));
    if (out_count_i !== want.count)
      report_mismatch($sformatf("count %0d, want %0d", out_count_i, want.count));
    if (out_last_i !== want.last)
      report_mismatch($sformatf("last %0b, want %0b", out_last_i, want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) predict_item(in_command_i, in_key_i);
      if (out_valid_i && !out_stall_i) check_result();
      pending = want_q.size();
    end
  end

endmodule

/* dv/sorted_set_list_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_list_top_tb: stimulus and verdict for the sorted set list
// Directed items cover the key extremes, every command and the corner cases;
// random items then fill, churn and drain the set under three idle patterns.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_set_list_top_tb;
  import ssl_pkg::*;

  // Command code 3 has no meaning; the block takes and drops it.
  localparam logic [CMD_W-1:0]        CMD_UNUSED   = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN      = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX      = 32'sh7fff_ffff;
  // Sized for the slowest correct run, even with the 85% stalls and
  // readouts of up to 32 keys.
  localparam int                      CYCLE_LIMIT  = 400_000;
  // Room for a readout of a full set to drain.
  localparam int                      DRAIN_CYCLES = 4 * CAPACITY + 16;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_command = CMD_INSERT;
  logic signed [KEY_W-1:0] in_key     = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic [ST_W-1:0]         out_status;
  logic signed [KEY_W-1:0] out_value;
  logic [OUT_CW-1:0]       out_count;
  logic                    out_last;

  int fail_count;
  int pending;
  int cycle_cnt   = 0;
  int tx_idle_pct = 0;  // chance per item slot that the sender holds off
  int rx_idle_pct = 0;  // chance per cycle that the receiver stalls

  always #2 clk = ~clk;

  sorted_set_list_top u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_command_i (in_command),
    .in_key_i     (in_key),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_status_o (out_status),
    .out_value_o  (out_value),
    .out_count_o  (out_count),
    .out_last_o   (out_last)
  );

  sorted_set_list_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_command_i (in_command),
    .in_key_i     (in_key),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_status_i (out_status),
    .out_value_i  (out_value),
    .out_count_i  (out_count),
    .out_last_i   (out_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Present one item and hold it until the block takes it. Valid stays high
  // between back-to-back items, so it is never dropped and raised in one step.
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic signed [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Key mix: full 32-bit patterns keep all bits toggling and are mostly new;
  // a small window around zero plus the extremes gives duplicates and hits.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned sel;
    int          near_zero;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom();
    if (sel == 4) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MIN;
        1:       return KEY_MIN + 1;
        2:       return KEY_MAX;
        default: return KEY_MAX - 1;
      endcase
    end
    near_zero = $urandom_range(0, 40);
    return near_zero - 20;
  endfunction

  // Weights in percent; whatever is left over goes to the undefined command.
  task automatic random_item(input int ins_w, input int del_w, input int rd_w);
    int unsigned      pick;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < ins_w)                      cmd = CMD_INSERT;
    else if (pick < ins_w + del_w)         cmd = CMD_DELETE;
    else if (pick < ins_w + del_w + rd_w)  cmd = CMD_READOUT;
    else                                   cmd = CMD_UNUSED;
    send_item(cmd, pick_key());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty cases, extremes, duplicate, ordering by sign,
    // deletes at head, tail and middle, alternating bit patterns.
    send_item(CMD_READOUT, '0);              // empty readout
    send_item(CMD_DELETE, 32'sd5);           // delete from empty set
    send_item(CMD_INSERT, 32'sd0);
    send_item(CMD_INSERT, KEY_MAX);
    send_item(CMD_INSERT, KEY_MIN);          // goes to the head
    send_item(CMD_INSERT, -32'sd1);
    send_item(CMD_INSERT, 32'sd1);
    send_item(CMD_INSERT, KEY_MAX);          // duplicate
    send_item(CMD_READOUT, '1);
    send_item(CMD_UNUSED, 32'sh1234_5678);   // dropped, no result
    send_item(CMD_DELETE, KEY_MIN);          // head
    send_item(CMD_DELETE, KEY_MAX);          // tail
    send_item(CMD_DELETE, 32'sd0);           // middle
    send_item(CMD_DELETE, 32'sd0);           // now absent
    send_item(CMD_INSERT, 32'sh5555_5555);
    send_item(CMD_INSERT, 32'shaaaa_aaaa);
    send_item(CMD_READOUT, '0);
    send_item(CMD_DELETE, -32'sd1);
    send_item(CMD_DELETE, 32'sd1);
    send_item(CMD_DELETE, 32'sh5555_5555);
    send_item(CMD_DELETE, 32'shaaaa_aaaa);
    send_item(CMD_READOUT, '0);              // empty again

    // Random: each phase fills the set past full, churns it, then drains it.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 25;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 25;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (45) random_item(88, 6, 4);
      repeat (60) random_item(40, 40, 15);
      repeat (48) random_item(15, 70, 12);
    end

    in_valid <= 1'b0;
    // Checker updates its queue on the rising edge; look on the falling one.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
